// File: design/sitda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned QUOT_W     = 29;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
  // ceil(2^35 / 10): exact quotient by ten for any 32-bit unsigned value
  localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;

  typedef struct packed {
    logic load;
    logic step;
    logic push_sign;
    logic push_digit;
  } ctl_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic out_free;
    logic last_digit;
    logic neg;
  } dp_stat_t;

endpackage : sitda_pkg
`default_nettype wire

// File: design/sitda_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude register, divide-by-ten step, digit stack and output
// register.
// ----------------------------------------------------------------------------
module sitda_dp
  import sitda_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [VALUE_W-1:0]  in_value,
  input  wire logic                out_stall,
  input  wire ctl_cmd_t            cmd,
  output dp_stat_t                 stat,
  output logic [CHAR_W-1:0]        out_char_code,
  output logic                     out_last,
  output logic                     out_valid
);

  logic [VALUE_W-1:0]   mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [3:0]           dig_r   [NUM_DIGITS];
  logic [3:0]           dig_nxt [NUM_DIGITS];
  logic [CHAR_W-1:0]    char_r, char_nxt;
  logic                 last_r, last_nxt;
  logic                 valid_r, valid_nxt;

  logic [2*VALUE_W-1:0] prod;
  logic [QUOT_W-1:0]    quot;
  logic [3:0]           quot_ten_lo;
  logic [3:0]           rem;

  assign prod        = {{VALUE_W{1'b0}}, mag_r} * {{VALUE_W{1'b0}}, RECIP_TEN};
  assign quot        = prod[2*VALUE_W-1:RECIP_SHIFT];
  assign quot_ten_lo = {quot[2:0], 1'b0} + {quot[0], 3'b000};
  assign rem         = mag_r[3:0] - quot_ten_lo;

  assign stat.conv_done  = (quot == '0) || (cnt_r == CNT_W'(NUM_DIGITS - 1));
  assign stat.out_free   = !valid_r || !out_stall;
  assign stat.last_digit = (cnt_r == CNT_W'(1));
  assign stat.neg        = neg_r;

  always_comb begin
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    dig_nxt   = dig_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    valid_nxt = valid_r && out_stall;
    if (cmd.load) begin
      neg_nxt = in_value[VALUE_W-1];
      mag_nxt = in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
      cnt_nxt = '0;
    end
    if (cmd.step) begin
      mag_nxt    = {{(VALUE_W-QUOT_W){1'b0}}, quot};
      cnt_nxt    = cnt_r + CNT_W'(1);
      dig_nxt[0] = rem;
      for (int i = 1; i < NUM_DIGITS; i++) begin
        dig_nxt[i] = dig_r[i-1];
      end
    end
    if (cmd.push_sign) begin
      char_nxt  = CHAR_MINUS;
      last_nxt  = 1'b0;
      valid_nxt = 1'b1;
    end
    if (cmd.push_digit) begin
      char_nxt  = CHAR_ZERO + {4'b0000, dig_r[0]};
      last_nxt  = (cnt_r == CNT_W'(1));
      valid_nxt = 1'b1;
      cnt_nxt   = cnt_r - CNT_W'(1);
      for (int i = 0; i < NUM_DIGITS - 1; i++) begin
        dig_nxt[i] = dig_r[i+1];
      end
      dig_nxt[NUM_DIGITS-1] = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    dig_r  <= dig_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_char_code = char_r;
  assign out_last      = last_r;
  assign out_valid     = valid_r;

endmodule : sitda_dp
`default_nettype wire

// File: design/sitda_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_ctrl
// Controller: sequences load, digit extraction, sign and digit output.
// ----------------------------------------------------------------------------
module sitda_ctrl
  import sitda_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (stat.conv_done) begin
          state_nxt = stat.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (stat.out_free) begin
          cmd.push_sign = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.push_digit = 1'b1;
          if (stat.last_digit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule : sitda_ctrl
`default_nettype wire

// File: design/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a 32-bit two's complement word to its decimal ASCII text, most
// significant character first, one character per output word.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   input   | in_valid, in_stall, in_value       | in
//   output  | out_valid, out_stall, out_char_code, out_last | out
//
// An item of D digits (1 to 10) is loaded, then takes D divide-by-ten steps
// (one multiply by the reciprocal of ten per cycle), then emits a minus
// sign if negative, followed by its D digits.
// Synchronous active-low reset clears the controller and output valid.
// out_stall holds the emit phase; in_stall stays high until the last
// character is in the output register.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [CHAR_W-1:0]       out_char_code,
  output logic                    out_last
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sitda_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .stat          (stat),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .out_valid     (out_valid)
  );

endmodule : signed_int_to_decimal_ascii
`default_nettype wire
